// ----- rtl/dnsrw_pkg.sv -----
// Shared types, constants and a helper function for the DNS redirect header rewriter.
// Used by dnsrw_check and dns_redirect_header_rewriter_top; depends on nothing else.
`timescale 1ns / 1ps

package dnsrw_pkg;

  localparam int unsigned HOLD_WORDS_DEF = 18;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_VPN_ADDR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VDNS_ADDR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PDNS_ADDR = 2'd2;

  localparam logic [3:0]  MIN_IHL     = 4'd5;
  localparam logic [7:0]  UDP_PROTO   = 8'd17;
  localparam logic [15:0] DNS_PORT    = 16'd53;
  localparam logic [15:0] MIN_UDP_LEN = 16'd21;
  localparam logic [15:0] HALF_ZERO   = 16'h0000;

  typedef struct packed {
    logic        decide;
    logic        matched;
    logic [15:0] csum;
    logic [3:0]  hw;
  } chk_t;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? (s[15:0] + 16'd1) : s[15:0];
  endfunction

endpackage

// ----- rtl/dnsrw_check.sv -----
// Header inspection: captures the fields that the match rule needs and keeps
// running header checksums for both directions. Depends on dnsrw_pkg.
`timescale 1ns / 1ps

module dnsrw_check
  import dnsrw_pkg::*;
#(
  parameter int unsigned HOLD_WORDS = HOLD_WORDS_DEF,
  localparam int unsigned IDX_W = $clog2(HOLD_WORDS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [IDX_W-1:0] idx_i,
  input  logic [31:0]      word_i,
  input  logic [15:0]      bytes_i,
  input  logic             query_i,
  input  logic [31:0]      vpn_addr_i,
  input  logic [31:0]      vdns_addr_i,
  input  logic [31:0]      pdns_addr_i,
  output chk_t             chk_o
);

  logic [3:0]       hw_q, hw_d;
  logic [15:0]      sum_q_q, sum_q_d;
  logic [15:0]      sum_r_q, sum_r_d;
  logic             proto_q, src_vpn_q, dst_vdns_q, dst_vpn_q, spm_q, dport_q;
  logic [15:0]      udp_len_q;
  logic [IDX_W-1:0] hw_x;
  logic [15:0]      base_q, base_r;
  logic [31:0]      add_q, add_r;
  logic [16:0]      len_need;
  logic             base_ok, query_ok, reply_ok;

  assign hw_x = IDX_W'(hw_q);
  assign hw_d = (idx_i == '0) ? word_i[27:24] : hw_q;

  always_comb begin
    base_q = (idx_i == '0) ? HALF_ZERO : sum_q_q;
    base_r = (idx_i == '0) ? HALF_ZERO : sum_r_q;
    priority if (idx_i == '0) begin
      add_q = word_i;
      add_r = word_i;
    end else if (idx_i == IDX_W'(2)) begin
      add_q = {word_i[31:16], HALF_ZERO};
      add_r = {word_i[31:16], HALF_ZERO};
    end else if (idx_i == IDX_W'(3)) begin
      add_q = word_i;
      add_r = vdns_addr_i;
    end else if (idx_i == IDX_W'(4)) begin
      add_q = pdns_addr_i;
      add_r = word_i;
    end else if (idx_i < hw_x) begin
      add_q = word_i;
      add_r = word_i;
    end else begin
      add_q = '0;
      add_r = '0;
    end
    sum_q_d = ones_add(ones_add(base_q, add_q[31:16]), add_q[15:0]);
    sum_r_d = ones_add(ones_add(base_r, add_r[31:16]), add_r[15:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q       <= '0;
      sum_q_q    <= '0;
      sum_r_q    <= '0;
      proto_q    <= 1'b0;
      src_vpn_q  <= 1'b0;
      dst_vdns_q <= 1'b0;
      dst_vpn_q  <= 1'b0;
      spm_q      <= 1'b0;
      dport_q    <= 1'b0;
      udp_len_q  <= '0;
    end else if (take_i) begin
      hw_q    <= hw_d;
      sum_q_q <= sum_q_d;
      sum_r_q <= sum_r_d;
      if (idx_i == IDX_W'(2)) begin
        proto_q <= (word_i[23:16] == UDP_PROTO);
      end
      if (idx_i == IDX_W'(3)) begin
        src_vpn_q <= (word_i == vpn_addr_i);
      end
      if (idx_i == IDX_W'(4)) begin
        dst_vdns_q <= (word_i == vdns_addr_i);
        dst_vpn_q  <= (word_i == vpn_addr_i);
      end
      if (idx_i != '0 && idx_i == hw_x) begin
        spm_q   <= (word_i[31:16] == DNS_PORT);
        dport_q <= (word_i[15:0] == DNS_PORT);
      end
      if (idx_i != '0 && idx_i == hw_x + IDX_W'(1)) begin
        udp_len_q <= word_i[31:16];
      end
    end
  end

  assign len_need = {11'b0, hw_q, 2'b00} + {1'b0, udp_len_q};
  assign base_ok  = (hw_q >= MIN_IHL) && proto_q && (udp_len_q >= MIN_UDP_LEN) &&
                    ({1'b0, bytes_i} >= len_need);
  assign query_ok = dport_q && dst_vdns_q && src_vpn_q && !word_i[15];
  assign reply_ok = spm_q && dst_vpn_q && word_i[15];

  always_comb begin
    chk_o.hw      = hw_q;
    chk_o.decide  = (idx_i == '0) ? (word_i[27:24] < MIN_IHL)
                                  : (idx_i == hw_x + IDX_W'(2));
    chk_o.matched = (idx_i != '0) && base_ok && (query_i ? query_ok : reply_ok);
    chk_o.csum    = ~(query_i ? sum_q_q : sum_r_q);
  end

endmodule

// ----- rtl/dns_redirect_header_rewriter_top.sv -----
// Top level of the DNS redirect header rewriter: hold memory, release sequencer,
// output register and configuration registers. Depends on dnsrw_pkg and dnsrw_check.
`timescale 1ns / 1ps
//
// The input channel takes one 32-bit packet word per item together with the
// packet length, a last-word flag and the direction. The output channel gives
// one word per item with its last flag and a rewritten flag. Both channels
// use valid and stall; the configuration channel writes the three address
// registers by index with valid and ready and is always ready.
// Header words are stored in a one-port hold memory until the DNS flags word
// (word IHL+2), the last word or a first word with IHL below 5 arrives. Each
// such word is taken with no output. The held words are then released
// through the memory, whose read is registered in S_READ before S_SHOW sends
// each word on, and the input stalls meanwhile. After the decision every
// further word passes through the output register, which takes a new word
// as the last one leaves unless the receiver stalls. A matching packet has
// its address, UDP checksum and header checksum substituted as the words
// leave the memory. Reset clears the configuration registers and all
// per-packet state; no memory clearing pass is needed. When the receiver
// stalls, the output word holds and the input stalls once a word is waiting.

module dns_redirect_header_rewriter_top
  import dnsrw_pkg::*;
#(
  parameter int unsigned HOLD_WORDS = HOLD_WORDS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [31:0]          packet_word_i,
  input  logic [15:0]          packet_bytes_i,
  input  logic                 last_word_i,
  input  logic                 is_query_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [31:0]          out_word_o,
  output logic                 out_last_o,
  output logic                 rewritten_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(HOLD_WORDS);

  typedef enum logic [2:0] {
    S_COLLECT = 3'b001,
    S_READ    = 3'b010,
    S_SHOW    = 3'b100
  } state_e;

  state_e           state_q;
  logic [31:0]      vpn_q, vdns_q, pdns_q;
  logic [IDX_W-1:0] idx_q, rel_idx_q, rel_end_q;
  logic             decided_q, matched_q, query_q, rel_last_q;
  logic [15:0]      csum_q;
  logic [31:0]      hold_mem [HOLD_WORDS];
  logic [31:0]      rd_q;
  logic             out_valid_q, out_last_q, rewritten_q;
  logic [31:0]      out_word_q;
  logic             in_acc, out_free, rel_done, take;
  logic [31:0]      rel_word;
  chk_t             chk;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !(state_q == S_COLLECT && (!decided_q || out_free));
  assign in_acc      = in_valid_i && !in_stall_o;
  assign take        = in_acc && !decided_q;
  assign rel_done    = (rel_idx_q == rel_end_q);

  dnsrw_check #(
    .HOLD_WORDS(HOLD_WORDS)
  ) u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .idx_i      (idx_q),
    .word_i     (packet_word_i),
    .bytes_i    (packet_bytes_i),
    .query_i    (is_query_i),
    .vpn_addr_i (vpn_q),
    .vdns_addr_i(vdns_q),
    .pdns_addr_i(pdns_q),
    .chk_o      (chk)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vpn_q  <= '0;
      vdns_q <= '0;
      pdns_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_VPN_ADDR:  vpn_q  <= cfg_data_i;
        REG_VDNS_ADDR: vdns_q <= cfg_data_i;
        REG_PDNS_ADDR: pdns_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      hold_mem[idx_q] <= packet_word_i;
    end
    if (state_q == S_READ) begin
      rd_q <= hold_mem[rel_idx_q];
    end
  end

  always_comb begin
    rel_word = rd_q;
    if (matched_q) begin
      priority if (rel_idx_q == IDX_W'(2)) begin
        rel_word = {rd_q[31:16], csum_q};
      end else if (rel_idx_q == IDX_W'(3) && !query_q) begin
        rel_word = vdns_q;
      end else if (rel_idx_q == IDX_W'(4) && query_q) begin
        rel_word = pdns_q;
      end else if (rel_idx_q == IDX_W'(chk.hw) + IDX_W'(1)) begin
        rel_word = {rd_q[31:16], HALF_ZERO};
      end else begin
        rel_word = rd_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_COLLECT;
      idx_q       <= '0;
      rel_idx_q   <= '0;
      rel_end_q   <= '0;
      decided_q   <= 1'b0;
      matched_q   <= 1'b0;
      query_q     <= 1'b0;
      rel_last_q  <= 1'b0;
      csum_q      <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
      out_last_q  <= 1'b0;
      rewritten_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_COLLECT: begin
          if (in_acc && decided_q) begin
            out_valid_q <= 1'b1;
            out_word_q  <= packet_word_i;
            out_last_q  <= last_word_i;
            rewritten_q <= matched_q;
            if (last_word_i) begin
              decided_q <= 1'b0;
              matched_q <= 1'b0;
              idx_q     <= '0;
            end
          end else if (take) begin
            if (chk.decide) begin
              decided_q <= 1'b1;
              matched_q <= chk.matched;
              csum_q    <= chk.csum;
              query_q   <= is_query_i;
            end
            if (chk.decide || last_word_i) begin
              rel_end_q  <= idx_q;
              rel_last_q <= last_word_i;
              rel_idx_q  <= '0;
              state_q    <= S_READ;
            end else begin
              idx_q <= idx_q + IDX_W'(1);
            end
          end
        end
        S_READ: begin
          state_q <= S_SHOW;
        end
        S_SHOW: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_word_q  <= rel_word;
            out_last_q  <= rel_last_q && rel_done;
            rewritten_q <= matched_q;
            if (rel_done) begin
              state_q <= S_COLLECT;
              if (rel_last_q) begin
                decided_q <= 1'b0;
                matched_q <= 1'b0;
                idx_q     <= '0;
              end
            end else begin
              rel_idx_q <= rel_idx_q + IDX_W'(1);
              state_q   <= S_READ;
            end
          end
        end
        default: state_q <= S_COLLECT;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_last_o  = out_last_q;
  assign rewritten_o = rewritten_q;

  a_match_needs_decision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    matched_q |-> decided_q)
    else $error("match flag set without a decision");

  a_release_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ || state_q == S_SHOW) |-> (rel_idx_q <= rel_end_q))
    else $error("release index ran past the held words");

  a_collect_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COLLECT && !decided_q)
      |-> ({1'b0, idx_q} < (IDX_W + 1)'(HOLD_WORDS)))
    else $error("hold index outside the memory");

  a_last_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHOW && out_free && rel_done && rel_last_q)
      |=> (!decided_q && idx_q == '0 && state_q == S_COLLECT))
    else $error("packet state not cleared after the final released word");

endmodule
